// File: hdl/swrl_pkg.sv
// swrl_pkg: shared types and constants for the sliding window rate limiter
// no dependencies; imported by every module of the block
`default_nettype none

package swrl_pkg;

  localparam int WINDOW_W   = 32;
  localparam int QUOTA_W    = 7;
  localparam int CMD_W      = 2;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTA  = 1'd1;

  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 32'd1000;
  localparam logic [QUOTA_W-1:0]  QUOTA_RESET  = 7'd64;

  typedef enum logic [CMD_W-1:0] {
    OP_RESERVE = 2'd0,
    OP_SUBMIT  = 2'd1,
    OP_CANCEL  = 2'd2,
    OP_BAD     = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_GRANTED  = 2'd0,
    ST_DENIED   = 2'd1,
    ST_ACCEPTED = 2'd2,
    ST_NO_RESV  = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_CHECK = 1'b1
  } state_t;

  // head of the command queue as seen by the back end
  typedef struct packed {
    logic valid;
    op_t  op;
  } q_head_t;

endpackage

`default_nettype wire

// File: hdl/swrl_front.sv
// swrl_front: input beat acceptance, command decode and a two-entry queue
// depends on swrl_pkg
`default_nettype none

module swrl_front
  import swrl_pkg::*;
#(
  parameter int TIME_WIDTH = 48
) (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_stall,
  input  wire  [CMD_W-1:0]       cmd,
  input  wire  [TIME_WIDTH-1:0]  now,
  output q_head_t                q_head,
  output logic [TIME_WIDTH-1:0]  q_now,
  input  wire                    q_pop
);

  localparam int QD = 2;

  op_t                   op_buf  [QD];
  logic [TIME_WIDTH-1:0] now_buf [QD];
  logic                  wr_ptr;
  logic                  rd_ptr;
  logic [1:0]            count;
  logic                  push;
  logic                  pop;
  op_t                   op_dec;

  always_comb begin
    case (cmd)
      2'd0:    op_dec = OP_RESERVE;
      2'd1:    op_dec = OP_SUBMIT;
      2'd2:    op_dec = OP_CANCEL;
      default: op_dec = OP_BAD;
    endcase
  end

  assign in_stall     = (count == 2'(QD));
  assign push         = in_valid && !in_stall;
  assign pop          = q_pop && (count != 2'd0);
  assign q_head.valid = (count != 2'd0);
  assign q_head.op    = op_buf[rd_ptr];
  assign q_now        = now_buf[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      op_buf[wr_ptr]  <= op_dec;
      now_buf[wr_ptr] <= now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hdl/swrl_back.sv
// swrl_back: command execution, expiry memory, slot counters and result register
// depends on swrl_pkg
`default_nettype none

module swrl_back
  import swrl_pkg::*;
#(
  parameter int MAX_SLOTS  = 64,
  parameter int TIME_WIDTH = 48
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire  [WINDOW_W-1:0]                 window_ticks,
  input  wire  [QUOTA_W-1:0]                  slot_quota,
  input  q_head_t                             q_head,
  input  wire  [TIME_WIDTH-1:0]               q_now,
  output logic                                q_pop,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [STATUS_W-1:0]                 status,
  output logic [TIME_WIDTH:0]                 next_free_time,
  output logic [$clog2(MAX_SLOTS+1)-1:0]      free_slots
);

  localparam int ET = TIME_WIDTH + 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int PW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int UW = (CW + 1 > QUOTA_W + 1) ? CW + 1 : QUOTA_W + 1;

  logic [ET-1:0] exp_mem [MAX_SLOTS];
  logic [ET-1:0] rd_data;
  logic          mem_we;
  logic [ET-1:0] wr_data;

  state_t                state, state_next;
  logic [PW-1:0]         head, head_next;
  logic [PW-1:0]         tail, tail_next;
  logic [CW-1:0]         busy, busy_next;
  logic [CW-1:0]         reserved, reserved_next;
  logic [TIME_WIDTH-1:0] cur_now, cur_now_next;

  logic                  load_out;
  status_t               status_res;
  logic [ET-1:0]         nft_res;
  logic                  out_free;
  status_t               status_q;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(MAX_SLOTS - 1)) ? '0 : p + PW'(1);
  endfunction

  function automatic logic [CW-1:0] calc_free(input logic [CW-1:0] b,
                                              input logic [CW-1:0] r,
                                              input logic [QUOTA_W-1:0] quota);
    logic [UW-1:0] qe;
    logic [UW-1:0] me;
    logic [UW-1:0] used;
    qe   = UW'(quota);
    me   = UW'(MAX_SLOTS);
    if (qe > me) qe = me;
    used = UW'(b) + UW'(r);
    return (used >= qe) ? '0 : CW'(qe - used);
  endfunction

  assign out_free = !out_valid || !out_stall;
  assign wr_data  = ET'(q_now) + ET'(window_ticks);

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    busy_next     = busy;
    reserved_next = reserved;
    cur_now_next  = cur_now;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    load_out      = 1'b0;
    status_res    = ST_NO_RESV;
    nft_res       = '0;
    case (state)
      S_IDLE: begin
        if (q_head.valid) begin
          if (q_head.op == OP_RESERVE) begin
            q_pop        = 1'b1;
            cur_now_next = q_now;
            state_next   = S_CHECK;
          end else if (out_free) begin
            q_pop    = 1'b1;
            load_out = 1'b1;
            case (q_head.op)
              OP_SUBMIT: begin
                if (reserved != '0 && busy < CW'(MAX_SLOTS)) begin
                  mem_we        = 1'b1;
                  tail_next     = ptr_inc(tail);
                  busy_next     = busy + CW'(1);
                  reserved_next = reserved - CW'(1);
                  status_res    = ST_ACCEPTED;
                end
              end
              OP_CANCEL: begin
                if (reserved != '0) begin
                  reserved_next = reserved - CW'(1);
                  status_res    = ST_ACCEPTED;
                end
              end
              default: status_res = ST_NO_RESV;
            endcase
          end
        end
      end
      S_CHECK: begin
        // retire one expired slot per cycle, then decide
        if (busy != '0 && ET'(cur_now) >= rd_data) begin
          head_next = ptr_inc(head);
          busy_next = busy - CW'(1);
        end else if (out_free) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
          if (calc_free(busy, reserved, slot_quota) != '0) begin
            reserved_next = reserved + CW'(1);
            status_res    = ST_GRANTED;
          end else begin
            status_res = ST_DENIED;
            nft_res    = (busy != '0) ? rd_data
                                      : ET'(cur_now) + ET'(window_ticks);
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) exp_mem[tail] <= wr_data;
    rd_data <= exp_mem[head_next];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      busy      <= '0;
      reserved  <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      head      <= head_next;
      tail      <= tail_next;
      busy      <= busy_next;
      reserved  <= reserved_next;
      out_valid <= load_out || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    cur_now <= cur_now_next;
    if (load_out) begin
      status_q       <= status_res;
      next_free_time <= nft_res;
      free_slots     <= calc_free(busy_next, reserved_next, slot_quota);
    end
  end

  assign status = status_q;

endmodule

`default_nettype wire

// File: hdl/sliding_window_rate_limiter.sv
// Sliding window rate limiter.
// Input channel (in_valid/in_stall) carries one command beat: cmd (reserve,
// submit, cancel) and the current time now. Output channel (out_valid/
// out_stall) returns one result beat per command: status, next_free_time
// (oldest busy expiry or now plus window when denied, else zero) and
// free_slots after the command. Config port: cfg_we/cfg_index/cfg_data,
// index 0 window_ticks, index 1 slot_quota; write only while idle.
// Commands pass through a two-entry queue to the execution engine; the
// result sits in an output register, so new beats are taken while a result
// waits. Submit, cancel and unknown commands are executed in the idle state.
// Reserve enters a check state that retires expired entries first, paced by
// the single read port of the expiry memory, which is walked one entry per
// cycle; the result is loaded into the output register once that is free.
// Reset clears counters and pointers, window to 1000, quota to 64; the
// expiry memory is not cleared and only written entries are read.
// When the receiver stalls, the result holds; once the queue fills, in_stall
// rises.
// depends on swrl_pkg, swrl_front, swrl_back
`default_nettype none

module sliding_window_rate_limiter
  import swrl_pkg::*;
#(
  parameter int MAX_SLOTS  = 64,
  parameter int TIME_WIDTH = 48
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              cfg_we,
  input  wire  [CFG_IDX_W-1:0]             cfg_index,
  input  wire  [CFG_DATA_W-1:0]            cfg_data,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [CMD_W-1:0]                 cmd,
  input  wire  [TIME_WIDTH-1:0]            now,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [STATUS_W-1:0]              status,
  output logic [TIME_WIDTH:0]              next_free_time,
  output logic [$clog2(MAX_SLOTS+1)-1:0]   free_slots
);

  logic [WINDOW_W-1:0]   window_ticks;
  logic [QUOTA_W-1:0]    slot_quota;
  q_head_t               q_head;
  logic [TIME_WIDTH-1:0] q_now;
  logic                  q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_ticks <= WINDOW_RESET;
      slot_quota   <= QUOTA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW: window_ticks <= cfg_data[WINDOW_W-1:0];
        CFG_QUOTA:  slot_quota   <= cfg_data[QUOTA_W-1:0];
        default:    window_ticks <= window_ticks;
      endcase
    end
  end

  swrl_front #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .now      (now),
    .q_head   (q_head),
    .q_now    (q_now),
    .q_pop    (q_pop)
  );

  swrl_back #(
    .MAX_SLOTS  (MAX_SLOTS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .window_ticks   (window_ticks),
    .slot_quota     (slot_quota),
    .q_head         (q_head),
    .q_now          (q_now),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .next_free_time (next_free_time),
    .free_slots     (free_slots)
  );

endmodule

`default_nettype wire

// File: hdl/swrl_checker.sv
// swrl_checker: port-level checks for the sliding window rate limiter
// depends on swrl_pkg; bound to sliding_window_rate_limiter
`default_nettype none

module swrl_checker
  import swrl_pkg::*;
#(
  parameter int MAX_SLOTS  = 64,
  parameter int TIME_WIDTH = 48
) (
  input wire                            clk,
  input wire                            rst,
  input wire                            out_valid,
  input wire                            out_stall,
  input wire [STATUS_W-1:0]             status,
  input wire [TIME_WIDTH:0]             next_free_time,
  input wire [$clog2(MAX_SLOTS+1)-1:0]  free_slots
);

  localparam int CW = $clog2(MAX_SLOTS + 1);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(status) && $stable(next_free_time)
                               && $stable(free_slots))
    else $error("stalled result beat changed");

  a_nft_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DENIED |-> next_free_time == '0)
    else $error("next free time set on a beat that is not a denial");

  a_free_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> free_slots <= CW'(MAX_SLOTS))
    else $error("free slots above capacity");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

endmodule

bind sliding_window_rate_limiter swrl_checker #(
  .MAX_SLOTS  (MAX_SLOTS),
  .TIME_WIDTH (TIME_WIDTH)
) u_swrl_checker (.*);

`default_nettype wire
